@@ rtl/core/qph_pkg.sv @@
// Shared types and constants for the quadratic probe hash table.
package qph_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int SIZE_W     = SLOT_W + 1;
  localparam int KEY_W      = 31;
  localparam int CNT_W      = 32;
  localparam int BIT_W      = $clog2(KEY_W);

  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(SLOT_COUNT);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] slot_index;
    logic              table_full;
    logic [CNT_W-1:0]  collision_total;
  } out_item_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       data;
  } mem_wr_t;

endpackage

@@ rtl/core/quadratic_probe_hash_table_core.sv @@
// Quadratic probe hash table core: insert, search and counter clear.
// Insert/search: accept, key mod m one remainder bit at a time, then a read and a check per probe, then finish.
// Clear and no-op items go straight from accept to finish; a stalled result holds the finish step.
// Speed is set by the single shared modular adder and the one-read-port slot memory.
// Reset (rst, synchronous) runs a sweep over all slots that marks every slot free; no item is
// accepted until it ends. table_size resets to 1024 and the collision counter to 0.
module quadratic_probe_hash_table_core import qph_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item
);

  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]        state;
  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] m_cur;       // clamped table size for the current item
  logic [SIZE_W-1:0] m_clamp;
  logic [SLOT_W-1:0] sweep_addr;

  logic [1:0]        action;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  div_shift;   // key bits fed MSB first into the remainder
  logic [BIT_W-1:0]  bit_cnt;
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W-1:0] slot;        // slot of the current probe
  logic [SLOT_W-1:0] step;        // (2i+1) mod m, distance to the next probe
  logic [SIZE_W-1:0] probes;      // probes already completed

  logic [CNT_W-1:0]  collisions;
  logic              res_success;
  logic [SLOT_W-1:0] res_slot;
  logic              res_full;

  logic [SLOT_W-1:0] unit_a;
  logic [SLOT_W-1:0] unit_b;
  logic              unit_cin;
  logic [SLOT_W-1:0] unit_y;

  mem_wr_t           wr;
  slot_entry_t       rd_data;

  logic              accept;
  logic              out_free;
  logic              hit;
  logic              is_insert;
  logic              last_probe;
  logic [CNT_W-1:0]  collisions_inc;

  // Clamp the configured size into 2 .. SLOT_COUNT.
  always_comb begin
    if (table_size < SIZE_MIN) begin
      m_clamp = SIZE_MIN;
    end else if (table_size > SIZE_MAX) begin
      m_clamp = SIZE_MAX;
    end else begin
      m_clamp = table_size;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !(out_valid && out_stall);
  assign is_insert = (action == ACT_INSERT);
  // A probe serves the request on a free slot for insert, a matching key for search.
  assign hit        = is_insert ? !rd_data.used : (rd_data.used && (rd_data.key == key));
  assign last_probe = (probes == (m_cur - SIZE_W'(1)));
  assign collisions_inc = (collisions == {CNT_W{1'b1}}) ? collisions
                                                        : collisions + CNT_W'(1);

  // Operand select for the shared modular adder: remainder doubling during
  // the divide, step advance on read, slot advance on check.
  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_cin = 1'b0;
    unique case (state)
      ST_DIV: begin
        unit_a   = rem;
        unit_b   = rem;
        unit_cin = div_shift[KEY_W-1];
      end
      ST_READ: begin
        unit_a = step;
        unit_b = SLOT_W'(2);
      end
      ST_CHECK: begin
        unit_a = slot;
        unit_b = step;
      end
      default: begin
        unit_a   = '0;
        unit_b   = '0;
        unit_cin = 1'b0;
      end
    endcase
  end

  qph_modadd u_modadd (
    .a   (unit_a),
    .b   (unit_b),
    .cin (unit_cin),
    .m   (m_cur),
    .y   (unit_y)
  );

  // Write port: the reset sweep clears entries, a successful insert claims one.
  always_comb begin
    wr = '0;
    if (state == ST_SWEEP) begin
      wr.en   = 1'b1;
      wr.addr = sweep_addr;
      wr.data = '0;
    end else if (state == ST_CHECK && is_insert && !rd_data.used) begin
      wr.en        = 1'b1;
      wr.addr      = slot;
      wr.data.used = 1'b1;
      wr.data.key  = key;
    end
  end

  qph_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      table_size <= SIZE_RESET;
      collisions <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_size <= cfg_wdata;
      end
      // Drop the result once taken; the finish step loads the next one itself.
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + SLOT_W'(1);
          if (sweep_addr == SLOT_W'(SLOT_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            action      <= in_item.action;
            key         <= in_item.key;
            div_shift   <= in_item.key;
            m_cur       <= m_clamp;
            rem         <= '0;
            bit_cnt     <= BIT_W'(KEY_W - 1);
            res_success <= 1'b0;
            res_slot    <= '0;
            res_full    <= 1'b0;
            if (in_item.action == ACT_INSERT || in_item.action == ACT_SEARCH) begin
              state <= ST_DIV;
            end else begin
              if (in_item.action == ACT_CLEAR) begin
                collisions <= '0;
              end
              state <= ST_FINISH;
            end
          end
        end

        ST_DIV: begin
          // One remainder bit per cycle: rem = (2*rem + bit) mod m.
          rem       <= unit_y;
          div_shift <= {div_shift[KEY_W-2:0], 1'b0};
          bit_cnt   <= bit_cnt - BIT_W'(1);
          if (bit_cnt == '0) begin
            slot   <= unit_y;
            step   <= m_cur[SLOT_W-1:0] - SLOT_W'(1);  // advances to 1 on first read
            probes <= '0;
            state  <= ST_READ;
          end
        end

        ST_READ: begin
          step  <= unit_y;
          state <= ST_CHECK;
        end

        ST_CHECK: begin
          if (hit) begin
            res_success <= 1'b1;
            res_slot    <= slot;
            state       <= ST_FINISH;
          end else if (!rd_data.used) begin
            // Search reached a free slot: miss, probe not counted.
            state <= ST_FINISH;
          end else begin
            collisions <= collisions_inc;
            probes     <= probes + SIZE_W'(1);
            slot       <= unit_y;
            if (last_probe) begin
              res_full <= is_insert;
              state    <= ST_FINISH;
            end else begin
              state <= ST_READ;
            end
          end
        end

        ST_FINISH: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_valid                <= 1'b1;
            out_item.success         <= res_success;
            out_item.slot_index      <= res_slot;
            out_item.table_full      <= res_full;
            out_item.collision_total <= collisions;
            state                    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/qph_modadd.sv @@
// Shared modular adder: y = (a + b + cin) mod m, for a + b + cin below 2*m.
module qph_modadd import qph_pkg::*; (
  input  logic [SLOT_W-1:0] a,
  input  logic [SLOT_W-1:0] b,
  input  logic              cin,
  input  logic [SIZE_W-1:0] m,
  output logic [SLOT_W-1:0] y
);

  logic [SLOT_W+1:0] sum;
  logic [SLOT_W+1:0] diff;

  always_comb begin
    sum  = {2'b00, a} + {2'b00, b} + {{(SLOT_W+1){1'b0}}, cin};
    diff = sum - {1'b0, m};
    if (sum >= {1'b0, m}) begin
      y = diff[SLOT_W-1:0];
    end else begin
      y = sum[SLOT_W-1:0];
    end
  end

endmodule

@@ rtl/core/qph_store.sv @@
// Slot memory: one write port, one registered read port.
module qph_store import qph_pkg::*; (
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_entry_t       rd_data
);

  slot_entry_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ tb/quadratic_probe_hash_table_core_tb.sv @@
// Testbench for the quadratic probe hash table core: directed, random and backpressure checks.
module quadratic_probe_hash_table_core_tb;
  import qph_pkg::*;

  // Action code 3 has no package name; the block treats it as a no-op.
  localparam logic [1:0]       ACT_NOP      = 2'd3;
  localparam logic [KEY_W-1:0] KEY_TOP      = '1;
  // Drain wait: about twice the longest insert/search at full size.
  localparam int               DRAIN_CYCLES = 4200;
  localparam int               HOLD_CYCLES  = 600;
  // Slowest correct run (every item walking a full 1024-slot probe sequence, long stalls)
  // stays well inside this limit, given in time units.
  localparam longint           LIMIT_TIME   = 64'd128_000_000;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  quadratic_probe_hash_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Shadow copy of the table: slot contents, occupancy, collision counter and size register.
  logic [KEY_W-1:0] slot_key  [SLOT_COUNT];
  bit               slot_used [SLOT_COUNT];
  logic [CNT_W-1:0] hit_total;
  logic [SIZE_W-1:0] size_reg;

  // Keys that were actually placed; searches draw from here to get hits.
  logic [KEY_W-1:0] stored_keys [$];
  // Results owed by the block, oldest first.
  out_item_t        replies_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;

  int unsigned n_items;
  int unsigned n_replies;
  int unsigned n_placed;
  int unsigned n_full;
  int unsigned n_found;
  int unsigned n_missed;
  int unsigned n_clears;
  int unsigned n_size_writes;
  int unsigned fault_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_TIME);
    $display("status: fail");
    $finish;
  end

  task automatic report_fault(input string msg);
    fault_count++;
    $display("MISMATCH: %s", msg);
  endtask

  // Size the block actually uses: the register clamped to the legal range.
  function automatic int unsigned active_modulus();
    if (size_reg < SIZE_MIN) return 32'(SIZE_MIN);
    if (size_reg > SIZE_MAX) return 32'(SIZE_MAX);
    return 32'(size_reg);
  endfunction

  // Apply one request to the shadow table and return the result it should produce.
  // Probe i visits ((key mod m) + i*i) mod m; each probe that hits an occupied slot
  // that does not serve the request bumps the saturating collision counter.
  function automatic out_item_t probe_and_update(input in_item_t rq);
    out_item_t   r;
    int unsigned m;
    int unsigned home;
    int unsigned s;
    int unsigned i;
    bit          done;
    m    = active_modulus();
    home = rq.key % m;
    r    = '0;
    done = 1'b0;
    i    = 0;
    case (rq.action)
      ACT_INSERT: begin
        // assume full until a free slot turns up within m probes
        r.table_full = 1'b1;
        while (!done && i < m) begin
          s = (home + i * i) % m;
          if (!slot_used[s]) begin
            slot_used[s] = 1'b1;
            slot_key[s]  = rq.key;
            r.success    = 1'b1;
            r.slot_index = s[SLOT_W-1:0];
            r.table_full = 1'b0;
            stored_keys.push_back(rq.key);
            done = 1'b1;
          end else begin
            if (hit_total != '1) hit_total++;
            i++;
          end
        end
        if (r.success) n_placed++;
        else n_full++;
      end
      ACT_SEARCH: begin
        // stop at the first free slot (not counted) or after m probes
        while (!done && i < m) begin
          s = (home + i * i) % m;
          if (!slot_used[s]) begin
            done = 1'b1;
          end else if (slot_key[s] == rq.key) begin
            r.success    = 1'b1;
            r.slot_index = s[SLOT_W-1:0];
            done = 1'b1;
          end else begin
            if (hit_total != '1) hit_total++;
            i++;
          end
        end
        if (r.success) n_found++;
        else n_missed++;
      end
      ACT_CLEAR: begin
        hit_total = '0;
        n_clears++;
      end
      default: ;
    endcase
    r.collision_total = hit_total;
    return r;
  endfunction

  // Offer one item, hold it until accepted, then record what it should produce.
  // Valid drops only when a gap is taken, so back-to-back items keep it high.
  task automatic send_item(input logic [1:0] act, input logic [KEY_W-1:0] key);
    in_item_t rq;
    rq.action = act;
    rq.key    = key;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= rq;
    do @(posedge clk); while (in_stall !== 1'b0);
    replies_due.push_back(probe_and_update(rq));
    n_items++;
  endtask

  // Drop valid and hold until every owed result has been taken.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // Change the table size only once the block has gone quiet.
  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    wait_for_replies();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_reg = value;
    n_size_writes++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    // mostly small tables so that they fill and probe sequences run long
    if (roll < 40) return SIZE_W'($urandom_range(16, 2));
    if (roll < 70) return SIZE_W'($urandom_range(400, 17));
    if (roll < 80) return SIZE_W'($urandom_range(1023, 401));
    if (roll < 90) return SIZE_MAX;
    // out-of-range values that the block must clamp
    if (roll[0]) return SIZE_W'($urandom_range(1, 0));
    return SIZE_W'($urandom_range(2047, 1025));
  endfunction

  // Random request: searches mostly look for keys already placed, inserts sometimes
  // repeat one, and most other keys sit in a narrow range so that homes collide.
  function automatic in_item_t pick_request();
    in_item_t    rq;
    int unsigned roll;
    int unsigned m;
    m    = active_modulus();
    roll = $urandom_range(99);
    if (roll < 45) rq.action = ACT_INSERT;
    else if (roll < 85) rq.action = ACT_SEARCH;
    else if (roll < 92) rq.action = ACT_CLEAR;
    else rq.action = ACT_NOP;
    roll = $urandom_range(99);
    if (roll < 60 && stored_keys.size() != 0 && (rq.action == ACT_SEARCH || roll < 12))
      rq.key = stored_keys[$urandom_range(stored_keys.size() - 1)];
    else if (roll < 80)
      rq.key = KEY_W'($urandom_range(4 * m));
    else
      rq.key = KEY_W'($urandom());
    return rq;
  endfunction

  // Extreme keys, duplicates, misses, no-op and counter clear at the reset size.
  task automatic test_directed_edges();
    send_item(ACT_INSERT, '0);
    send_item(ACT_INSERT, KEY_TOP);
    send_item(ACT_INSERT, '0);               // duplicate lands one probe further
    send_item(ACT_SEARCH, '0);
    send_item(ACT_SEARCH, KEY_TOP);
    send_item(ACT_SEARCH, KEY_W'(1024));     // same home as 0, stops at a free slot
    send_item(ACT_INSERT, KEY_W'(1024));
    send_item(ACT_NOP, KEY_TOP);
    send_item(ACT_CLEAR, '0);
    send_item(ACT_SEARCH, KEY_W'(1024));
    send_item(ACT_INSERT, KEY_W'(31'h2AAA_AAAA));
    send_item(ACT_SEARCH, KEY_W'(31'h5555_5555));
  endtask

  // Clamped sizes, full probe sequences, and a store kept across size changes.
  task automatic test_size_limits();
    write_table_size('0);                    // clamps to 2, both slots already taken
    send_item(ACT_INSERT, KEY_W'(9));
    send_item(ACT_SEARCH, KEY_TOP);          // its slot lies out of reach now
    send_item(ACT_SEARCH, '0);
    write_table_size(SIZE_W'(1));
    send_item(ACT_INSERT, '0);
    // with 8 slots, i*i mod 8 only reaches offsets 0, 1 and 4
    write_table_size(SIZE_W'(8));
    send_item(ACT_INSERT, KEY_W'(3));
    send_item(ACT_INSERT, KEY_W'(11));
    send_item(ACT_INSERT, KEY_W'(19));
    send_item(ACT_INSERT, KEY_W'(27));       // every reachable slot taken
    send_item(ACT_SEARCH, KEY_W'(19));
    send_item(ACT_SEARCH, KEY_W'(27));
    write_table_size(SIZE_W'(2047));
    send_item(ACT_SEARCH, KEY_W'(11));       // home moved with the size
    send_item(ACT_INSERT, KEY_TOP);
    write_table_size(SIZE_W'(1025));
    send_item(ACT_SEARCH, KEY_TOP);
    write_table_size(SIZE_MAX);
    send_item(ACT_CLEAR, KEY_TOP);
  endtask

  // Random traffic in three idling patterns, with a new table size every burst.
  task automatic test_random_traffic();
    int unsigned tx_pct [3];
    int unsigned rx_pct [3];
    int unsigned sent;
    int unsigned burst;
    in_item_t    rq;
    tx_pct = '{32, 46, 0};
    rx_pct = '{46, 32, 0};
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = tx_pct[mode];
      recv_stall_pct = rx_pct[mode];
      sent = 0;
      while (sent < 130) begin
        write_table_size(pick_size());
        burst = $urandom_range(35, 15);
        repeat (burst) begin
          rq = pick_request();
          send_item(rq.action, rq.key);
          sent++;
        end
      end
    end
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the block backs up and stalls its input.
  task automatic test_output_hold();
    in_item_t rq;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_table_size(SIZE_W'(32));
    hold_req = 1'b1;
    repeat (14) begin
      rq = pick_request();
      send_item(rq.action, rq.key);
    end
  endtask

  // Short bursts, each followed by a pause until every result is back.
  task automatic test_sender_pause();
    in_item_t rq;
    send_idle_pct  = 32;
    recv_stall_pct = 46;
    write_table_size(pick_size());
    repeat (3) begin
      repeat (6) begin
        rq = pick_request();
        send_item(rq.action, rq.key);
      end
      wait_for_replies();
    end
  endtask

  // Result side: random stalls, or one long hold when a test asks for it.
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest one owed.
  always @(posedge clk) begin : reply_check
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_replies++;
      if (replies_due.size() == 0) begin
        report_fault($sformatf("result %0d arrived with nothing owed", n_replies));
      end else begin
        want = replies_due.pop_front();
        if (out_item.success !== want.success)
          report_fault($sformatf("result %0d success %b, want %b",
                                 n_replies, out_item.success, want.success));
        if (out_item.slot_index !== want.slot_index)
          report_fault($sformatf("result %0d slot_index %0d, want %0d",
                                 n_replies, out_item.slot_index, want.slot_index));
        if (out_item.table_full !== want.table_full)
          report_fault($sformatf("result %0d table_full %b, want %b",
                                 n_replies, out_item.table_full, want.table_full));
        if (out_item.collision_total !== want.collision_total)
          report_fault($sformatf("result %0d collision_total %0d, want %0d",
                                 n_replies, out_item.collision_total, want.collision_total));
      end
    end
  end

  initial begin : main_seq
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    hold_req  = 1'b0;
    send_idle_pct  = 32;
    recv_stall_pct = 46;
    foreach (slot_used[k]) slot_used[k] = 1'b0;
    hit_total = '0;
    size_reg  = SIZE_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // the clearing sweep after reset keeps input stalled; items just wait

    test_directed_edges();
    test_size_limits();
    test_random_traffic();
    test_output_hold();
    test_sender_pause();

    wait_for_replies();
    // linger long enough that any stray result would show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d inserts placed, %0d refused as full, %0d hits, %0d misses",
             n_items, n_placed, n_full, n_found, n_missed);
    $display("%0d size writes incl. clamped ones, %0d clears, %0d results checked, %0d faults",
             n_size_writes, n_clears, n_replies, fault_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/qph_pkg.sv
rtl/core/qph_modadd.sv
rtl/core/qph_store.sv
rtl/core/quadratic_probe_hash_table_core.sv
tb/quadratic_probe_hash_table_core_tb.sv
